/* rtl/core/selective_repeat_receiver_window_core_macros.svh */
// Assertion macros for the selective-repeat receiver window core.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef SELECTIVE_REPEAT_RECEIVER_WINDOW_CORE_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVER_WINDOW_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SRRW_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("srrw: property violated");
`define SRRW_NEVER(name, clk, rstn, cond) \
    name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("srrw: forbidden condition");
`else
`define SRRW_ASSERT(name, clk, rstn, prop)
`define SRRW_NEVER(name, clk, rstn, cond)
`endif
`endif

/* rtl/core/srrw_pkg.sv */
// Shared constants, codes and types of the selective-repeat receiver window core.
// No dependencies; used by the top level, srrw_ctrl and srrw_out_reg.
package srrw_pkg;

    localparam int WINDOW  = 32;                    // power of two
    localparam int MAX_RES = 32;                    // results per item
    localparam int IDX_W   = $clog2(WINDOW);
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int GAP_W   = $clog2(MAX_RES);
    localparam int SEQ_W   = 31;
    localparam int SRC_W   = 32;
    localparam int NUM_W   = 32;
    localparam int TAG_W   = NUM_W - IDX_W;         // window index, base = tag * WINDOW
    localparam int IN_DATA_W  = ((SEQ_W + SRC_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((NUM_W + 2 + 7) / 8) * 8;

    typedef enum logic [1:0] {
        REQ_DATA  = 2'd0,
        REQ_START = 2'd1,
        REQ_TICK  = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        RPL_ACK    = 2'd0,
        RPL_NACK   = 2'd1,
        RPL_REJECT = 2'd2
    } reply_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_GAP,
        ST_FULL,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_SCAN_END,
        ST_TACK
    } state_t;

    typedef struct packed {
        logic               valid;
        reply_t             kind;
        logic [NUM_W-1:0]   num;
        logic               win_done;
        logic               xfer_done;
        logic               last;
    } emit_t;

endpackage

/* rtl/core/selective_repeat_receiver_window_core.sv */
// Top level of the selective-repeat receiver window core.
// Depends on srrw_pkg, srrw_slot_ram, srrw_ctrl and srrw_out_reg.
//
//  channel | dir | tdata (low bit up)                     | tuser       | tlast
//  s_      | in  | seq_no[30:0], source_id[62:31]         | req_type    | end_marker
//  m_      | out | reply_number[31:0], window_done,       | reply_kind  | last
//          |     | transfer_done                          |             |
//
// A frame passes a slot-tag read and a decide step, then emits one NACK per gap and
// an ACK for a full window; a timeout reads and evaluates each scanned slot in turn.
// The slot-tag memory read is registered, and a single result register holds each reply.
// Synchronous active-low reset; no clearing pass, slots are tagged per window.
// A stalled master side holds the sequencer; s_tready is high only between items.
module selective_repeat_receiver_window_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [srrw_pkg::IN_DATA_W-1:0]    s_tdata,   // seq_no, source_id
    input  logic [1:0]                        s_tuser,   // req_type
    input  logic                              s_tlast,   // end_marker
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [srrw_pkg::OUT_DATA_W-1:0]   m_tdata,   // reply_number, window_done, transfer_done
    output logic [1:0]                        m_tuser,   // reply_kind
    output logic                              m_tlast
);

    srrw_pkg::emit_t                 emit;
    logic                            out_take;
    logic                            ram_we;
    logic [srrw_pkg::IDX_W-1:0]      ram_waddr;
    logic [srrw_pkg::TAG_W-1:0]      ram_wdata;
    logic                            ram_re;
    logic [srrw_pkg::IDX_W-1:0]      ram_raddr;
    logic [srrw_pkg::TAG_W-1:0]      ram_rdata;

    srrw_slot_ram #(
        .DEPTH (srrw_pkg::WINDOW),
        .WIDTH (srrw_pkg::TAG_W)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    srrw_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (s_tuser),
        .in_seq    (s_tdata[srrw_pkg::SEQ_W-1:0]),
        .in_src    (s_tdata[srrw_pkg::SEQ_W+srrw_pkg::SRC_W-1:srrw_pkg::SEQ_W]),
        .in_eof    (s_tlast),
        .out_take  (out_take),
        .emit      (emit),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    srrw_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .emit     (emit),
        .take     (out_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/core/srrw_slot_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module srrw_slot_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/srrw_out_reg.sv */
// Result register: holds one item for the master side and frees the sequencer.
// Depends on srrw_pkg (emit_t, widths).
module srrw_out_reg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  srrw_pkg::emit_t                  emit,
    output logic                             take,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [srrw_pkg::OUT_DATA_W-1:0]  m_tdata,   // reply_number, window_done, transfer_done
    output logic [1:0]                       m_tuser,   // reply_kind
    output logic                             m_tlast
);

    logic                        valid_reg;
    logic [srrw_pkg::NUM_W-1:0]  num_reg;
    srrw_pkg::reply_t            kind_reg;
    logic                        wd_reg;
    logic                        td_reg;
    logic                        last_reg;

    assign take = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= emit.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && emit.valid) begin
            num_reg  <= emit.num;
            kind_reg <= emit.kind;
            wd_reg   <= emit.win_done;
            td_reg   <= emit.xfer_done;
            last_reg <= emit.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(srrw_pkg::OUT_DATA_W - srrw_pkg::NUM_W - 2){1'b0}},
                       td_reg, wd_reg, num_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

/* rtl/core/srrw_ctrl.sv */
// Window sequencer: session registers, slot-tag read/modify/write, gap and timeout scans.
// Depends on srrw_pkg and the assertion macro header.
`include "selective_repeat_receiver_window_core_macros.svh"
module srrw_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     in_req,
    input  logic [srrw_pkg::SEQ_W-1:0]     in_seq,
    input  logic [srrw_pkg::SRC_W-1:0]     in_src,
    input  logic                           in_eof,
    input  logic                           out_take,
    output srrw_pkg::emit_t                emit,
    output logic                           ram_we,
    output logic [srrw_pkg::IDX_W-1:0]     ram_waddr,
    output logic [srrw_pkg::TAG_W-1:0]     ram_wdata,
    output logic                           ram_re,
    output logic [srrw_pkg::IDX_W-1:0]     ram_raddr,
    input  logic [srrw_pkg::TAG_W-1:0]     ram_rdata
);

    localparam int IDX_W = srrw_pkg::IDX_W;
    localparam int CNT_W = srrw_pkg::CNT_W;
    localparam int GAP_W = srrw_pkg::GAP_W;
    localparam int SEQ_W = srrw_pkg::SEQ_W;
    localparam int SRC_W = srrw_pkg::SRC_W;
    localparam int NUM_W = srrw_pkg::NUM_W;
    localparam int TAG_W = srrw_pkg::TAG_W;

    srrw_pkg::state_t state_reg, state_next;

    logic [SRC_W-1:0]             sender_reg, sender_next;
    logic [srrw_pkg::WINDOW-1:0]  written_reg, written_next;
    logic [TAG_W-1:0]             tag_reg, tag_next;
    logic [NUM_W-1:0]             ne_reg, ne_next;
    logic [CNT_W-1:0]             fc_reg, fc_next;
    logic                         awaiting_reg, awaiting_next;
    logic                         end_seen_reg, end_seen_next;
    logic                         closed_reg, closed_next;
    logic [GAP_W-1:0]             gap_left_reg, gap_left_next;
    logic                         full_reg, full_next;
    logic                         pend_valid_reg, pend_valid_next;

    logic [SEQ_W-1:0]             seq_reg, seq_next;
    logic [SRC_W-1:0]             src_reg, src_next;
    logic                         eof_reg, eof_next;
    logic [NUM_W-1:0]             gap_num_reg, gap_num_next;
    logic [NUM_W-1:0]             pend_num_reg, pend_num_next;
    logic [CNT_W-1:0]             scan_k_reg, scan_k_next;
    logic [CNT_W-1:0]             scan_len_reg, scan_len_next;

    // frame decision
    logic [NUM_W-1:0]  lo;
    logic [NUM_W-1:0]  win_last;
    logic [IDX_W-1:0]  d_idx;
    logic              d_filled;
    logic              d_in_win;
    logic              d_accept;
    logic [CNT_W-1:0]  d_fc;
    logic              d_full;
    logic [NUM_W-1:0]  d_seq;
    logic              d_gap_en;
    logic [NUM_W-1:0]  d_diff;
    logic [GAP_W-1:0]  d_gcount;
    // timeout scan
    logic [IDX_W-1:0]  s_idx;
    logic              s_free;
    logic [NUM_W-1:0]  s_num;
    logic [CNT_W-1:0]  s_k_inc;
    logic [NUM_W-1:0]  t_span;
    logic [CNT_W-1:0]  t_len;
    logic [NUM_W-1:0]  t_ack;
    logic              t_adv;
    logic              td_now;

    assign lo       = {tag_reg, {IDX_W{1'b0}}};
    assign win_last = {tag_reg, {IDX_W{1'b1}}};
    assign td_now   = end_seen_reg && !closed_reg;

    assign d_idx    = seq_reg[IDX_W-1:0];
    assign d_filled = written_reg[d_idx] && (ram_rdata == tag_reg);
    assign d_in_win = TAG_W'(seq_reg[SEQ_W-1:IDX_W]) == tag_reg;
    assign d_accept = !d_filled && d_in_win;
    assign d_fc     = fc_reg + CNT_W'(d_accept);
    assign d_full   = d_fc == CNT_W'(srrw_pkg::WINDOW);
    assign d_seq    = NUM_W'(seq_reg);
    assign d_gap_en = d_accept && !eof_reg && (d_seq >= ne_reg);
    assign d_diff   = d_seq - ne_reg;
    assign d_gcount = !d_gap_en ? '0 :
                      (d_diff > NUM_W'(srrw_pkg::MAX_RES - 1)) ?
                      GAP_W'(srrw_pkg::MAX_RES - 1) : d_diff[GAP_W-1:0];

    assign s_idx   = scan_k_reg[IDX_W-1:0];
    assign s_free  = !(written_reg[s_idx] && (ram_rdata == tag_reg));
    assign s_num   = lo + NUM_W'(scan_k_reg);
    assign s_k_inc = scan_k_reg + CNT_W'(1);
    assign t_span  = ne_reg - lo;
    assign t_len   = (t_span > NUM_W'(srrw_pkg::WINDOW)) ?
                     CNT_W'(srrw_pkg::WINDOW) : t_span[CNT_W-1:0];
    assign t_ack   = ne_reg - NUM_W'(1);
    assign t_adv   = t_ack == win_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= srrw_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sender_reg     <= '0;
            written_reg    <= '0;
            tag_reg        <= '0;
            ne_reg         <= '0;
            fc_reg         <= '0;
            awaiting_reg   <= 1'b1;
            end_seen_reg   <= 1'b0;
            closed_reg     <= 1'b0;
            gap_left_reg   <= '0;
            full_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            sender_reg     <= sender_next;
            written_reg    <= written_next;
            tag_reg        <= tag_next;
            ne_reg         <= ne_next;
            fc_reg         <= fc_next;
            awaiting_reg   <= awaiting_next;
            end_seen_reg   <= end_seen_next;
            closed_reg     <= closed_next;
            gap_left_reg   <= gap_left_next;
            full_reg       <= full_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        seq_reg      <= seq_next;
        src_reg      <= src_next;
        eof_reg      <= eof_next;
        gap_num_reg  <= gap_num_next;
        pend_num_reg <= pend_num_next;
        scan_k_reg   <= scan_k_next;
        scan_len_reg <= scan_len_next;
    end

    always_comb begin
        state_next      = state_reg;
        sender_next     = sender_reg;
        written_next    = written_reg;
        tag_next        = tag_reg;
        ne_next         = ne_reg;
        fc_next         = fc_reg;
        awaiting_next   = awaiting_reg;
        end_seen_next   = end_seen_reg;
        closed_next     = closed_reg;
        gap_left_next   = gap_left_reg;
        full_next       = full_reg;
        pend_valid_next = pend_valid_reg;
        seq_next        = seq_reg;
        src_next        = src_reg;
        eof_next        = eof_reg;
        gap_num_next    = gap_num_reg;
        pend_num_next   = pend_num_reg;
        scan_k_next     = scan_k_reg;
        scan_len_next   = scan_len_reg;

        in_ready  = 1'b0;
        emit      = '0;
        ram_we    = 1'b0;
        ram_waddr = d_idx;
        ram_wdata = tag_reg;
        ram_re    = 1'b0;
        ram_raddr = in_seq[IDX_W-1:0];

        unique case (state_reg)
            srrw_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    seq_next = in_seq;
                    src_next = in_src;
                    eof_next = in_eof;
                    unique case (srrw_pkg::req_t'(in_req))
                        srrw_pkg::REQ_DATA, srrw_pkg::REQ_START: begin
                            ram_re     = 1'b1;
                            state_next = srrw_pkg::ST_DECIDE;
                        end
                        srrw_pkg::REQ_TICK: begin
                            if (!awaiting_reg) begin
                                if (ne_reg > lo) begin
                                    scan_k_next     = '0;
                                    scan_len_next   = t_len;
                                    pend_valid_next = 1'b0;
                                    state_next      = srrw_pkg::ST_SCAN_RD;
                                end else begin
                                    state_next = srrw_pkg::ST_TACK;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            srrw_pkg::ST_DECIDE: begin
                priority if (end_seen_reg && closed_reg) begin
                    // finished session: restart from this frame
                    emit.valid = 1'b1;
                    emit.kind  = srrw_pkg::RPL_ACK;
                    emit.num   = d_seq;
                    emit.last  = 1'b1;
                    if (out_take) begin
                        sender_next   = src_reg;
                        awaiting_next = 1'b0;
                        written_next  = '0;
                        tag_next      = '0;
                        ne_next       = '0;
                        fc_next       = '0;
                        end_seen_next = 1'b0;
                        closed_next   = 1'b0;
                        state_next    = srrw_pkg::ST_IDLE;
                    end
                end else if (!awaiting_reg && (src_reg != sender_reg)) begin
                    emit.valid = 1'b1;
                    emit.kind  = srrw_pkg::RPL_REJECT;
                    emit.last  = 1'b1;
                    if (out_take) begin
                        state_next = srrw_pkg::ST_IDLE;
                    end
                end else if (awaiting_reg) begin
                    emit.valid = 1'b1;
                    emit.kind  = srrw_pkg::RPL_ACK;
                    emit.num   = d_seq;
                    emit.last  = 1'b1;
                    if (out_take) begin
                        sender_next   = src_reg;
                        awaiting_next = 1'b0;
                        state_next    = srrw_pkg::ST_IDLE;
                    end
                end else begin
                    if (d_accept) begin
                        ram_we              = 1'b1;
                        written_next[d_idx] = 1'b1;
                        fc_next             = d_fc;
                        if (eof_reg) begin
                            end_seen_next = 1'b1;
                            ne_next       = d_seq + NUM_W'(1);
                        end else if (d_gap_en) begin
                            ne_next = d_seq + NUM_W'(1);
                        end
                    end
                    gap_num_next  = ne_reg;
                    gap_left_next = d_gcount;
                    full_next     = d_full;
                    if (d_gcount != '0) begin
                        state_next = srrw_pkg::ST_GAP;
                    end else if (d_full) begin
                        state_next = srrw_pkg::ST_FULL;
                    end else begin
                        state_next = srrw_pkg::ST_IDLE;
                    end
                end
            end

            srrw_pkg::ST_GAP: begin
                emit.valid = 1'b1;
                emit.kind  = srrw_pkg::RPL_NACK;
                emit.num   = gap_num_reg;
                emit.last  = (gap_left_reg == GAP_W'(1)) && !full_reg;
                if (out_take) begin
                    gap_num_next  = gap_num_reg + NUM_W'(1);
                    gap_left_next = gap_left_reg - GAP_W'(1);
                    if (gap_left_reg == GAP_W'(1)) begin
                        state_next = full_reg ? srrw_pkg::ST_FULL : srrw_pkg::ST_IDLE;
                    end
                end
            end

            srrw_pkg::ST_FULL: begin
                // full window: cumulative ack at the top slot, window moves on
                emit.valid     = 1'b1;
                emit.kind      = srrw_pkg::RPL_ACK;
                emit.num       = win_last;
                emit.win_done  = 1'b1;
                emit.xfer_done = td_now;
                emit.last      = 1'b1;
                if (out_take) begin
                    closed_next = closed_reg || td_now;
                    tag_next    = tag_reg + TAG_W'(1);
                    fc_next     = '0;
                    state_next  = srrw_pkg::ST_IDLE;
                end
            end

            srrw_pkg::ST_SCAN_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = s_idx;
                state_next = srrw_pkg::ST_SCAN_EV;
            end

            srrw_pkg::ST_SCAN_EV: begin
                // one free slot is held back so the final nack can carry last
                if (s_free && pend_valid_reg) begin
                    emit.valid = 1'b1;
                    emit.kind  = srrw_pkg::RPL_NACK;
                    emit.num   = pend_num_reg;
                end
                if (!(s_free && pend_valid_reg) || out_take) begin
                    if (s_free) begin
                        pend_valid_next = 1'b1;
                        pend_num_next   = s_num;
                    end
                    scan_k_next = s_k_inc;
                    state_next  = (s_k_inc == scan_len_reg) ?
                                  srrw_pkg::ST_SCAN_END : srrw_pkg::ST_SCAN_RD;
                end
            end

            srrw_pkg::ST_SCAN_END: begin
                if (pend_valid_reg) begin
                    emit.valid = 1'b1;
                    emit.kind  = srrw_pkg::RPL_NACK;
                    emit.num   = pend_num_reg;
                    emit.last  = 1'b1;
                    if (out_take) begin
                        pend_valid_next = 1'b0;
                        state_next      = srrw_pkg::ST_IDLE;
                    end
                end else begin
                    state_next = srrw_pkg::ST_TACK;
                end
            end

            srrw_pkg::ST_TACK: begin
                emit.valid     = 1'b1;
                emit.kind      = srrw_pkg::RPL_ACK;
                emit.num       = t_ack;
                emit.win_done  = t_adv;
                emit.xfer_done = td_now;
                emit.last      = 1'b1;
                if (out_take) begin
                    closed_next = closed_reg || td_now;
                    if (t_adv) begin
                        tag_next = tag_reg + TAG_W'(1);
                        fc_next  = '0;
                    end
                    state_next = srrw_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = srrw_pkg::ST_IDLE;
            end
        endcase
    end

    `SRRW_ASSERT(a_wait_clean, aclk, aresetn, awaiting_reg |-> (fc_reg == '0 && written_reg == '0))
    `SRRW_ASSERT(a_closed_end, aclk, aresetn, closed_reg |-> end_seen_reg)
    `SRRW_NEVER(a_fc_range, aclk, aresetn, fc_reg > CNT_W'(srrw_pkg::WINDOW))
    `SRRW_ASSERT(a_adv_clear, aclk, aresetn, (state_reg == srrw_pkg::ST_FULL && out_take) |=> (fc_reg == '0))
    `SRRW_ASSERT(a_scan_k, aclk, aresetn, (state_reg == srrw_pkg::ST_SCAN_EV) |-> (scan_k_reg < scan_len_reg))

endmodule
